/* rtl/lps_pkg.sv */
// Shared types and constants for the line pixel stepper.
package lps_pkg;

	// Item kind carried on s_tuser
	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_STEP = 1'b1;

	// Leftmost pixel of a byte sits in the MSB
	localparam logic [7:0] MASK_MSB = 8'h80;

	// Reset value of the bytes-per-line register
	localparam logic [7:0] BPL_RESET = 8'd80;

	// Per-pixel flags passed from the step stage to the address stage
	typedef struct packed {
		logic valid_res;
		logic colour;
		logic last;
	} pix_flags_t;

endpackage

/* rtl/lps_step.sv */
// Line state registers and the single-step Bresenham update.
module lps_step #(
	parameter int COORD_BITS = 10
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    func,
	input  logic [15:0]             layer_base,
	input  logic [COORD_BITS-1:0]   x_start,
	input  logic [COORD_BITS-1:0]   y_start,
	input  logic [COORD_BITS-1:0]   x_end,
	input  logic [COORD_BITS-1:0]   y_end,
	input  logic                    pen,
	output logic [COORD_BITS-1:0]   pix_x,
	output logic [COORD_BITS-1:0]   pix_y,
	output logic [15:0]             pix_base,
	output lps_pkg::pix_flags_t     pix_flags
);
	import lps_pkg::*;

	localparam int CB = COORD_BITS;
	localparam int EW = COORD_BITS + 3;

	logic [CB-1:0]        cur_x_q, cur_y_q, goal_x_q, goal_y_q;
	logic [CB:0]          tdx_q, tdy_q;
	logic signed [EW-1:0] err_q;
	logic                 x_neg_q, y_neg_q, x_major_q, busy_q, colour_q;
	logic [15:0]          base_q;

	// load-side values
	logic                 ld_x_neg, ld_y_neg, ld_x_major;
	logic [CB-1:0]        ld_dx, ld_dy;
	logic [CB:0]          ld_tdx, ld_tdy;
	logic signed [EW-1:0] ld_err;

	// step-side values
	logic                 err_nonneg;
	logic [CB-1:0]        mv_x, mv_y, st_x, st_y;
	logic signed [EW-1:0] st_err, e_tdx, e_tdy;

	// next state
	logic [CB-1:0]        nx_x, nx_y;
	logic                 nx_done;
	logic                 is_load, is_step;

	// Deltas, directions and initial error for a load
	always_comb begin
		ld_x_neg   = x_end < x_start;
		ld_y_neg   = y_end < y_start;
		ld_dx      = ld_x_neg ? (x_start - x_end) : (x_end - x_start);
		ld_dy      = ld_y_neg ? (y_start - y_end) : (y_end - y_start);
		ld_tdx     = {ld_dx, 1'b0};
		ld_tdy     = {ld_dy, 1'b0};
		ld_x_major = ld_dx > ld_dy;
		if (ld_x_major) begin
			ld_err = $signed({2'b00, ld_tdy}) - $signed({3'b000, ld_dx});
		end else begin
			ld_err = $signed({2'b00, ld_tdx}) - $signed({3'b000, ld_dy});
		end
	end

	// One Bresenham step from the held state
	always_comb begin
		err_nonneg = !err_q[EW-1];
		e_tdx      = $signed({2'b00, tdx_q});
		e_tdy      = $signed({2'b00, tdy_q});
		mv_x       = x_neg_q ? (cur_x_q - 1'b1) : (cur_x_q + 1'b1);
		mv_y       = y_neg_q ? (cur_y_q - 1'b1) : (cur_y_q + 1'b1);
		if (x_major_q) begin
			st_x   = mv_x;
			st_y   = err_nonneg ? mv_y : cur_y_q;
			st_err = err_q + e_tdy - (err_nonneg ? e_tdx : '0);
		end else begin
			st_x   = err_nonneg ? mv_x : cur_x_q;
			st_y   = mv_y;
			st_err = err_q + e_tdx - (err_nonneg ? e_tdy : '0);
		end
	end

	// Pixel of this item and end test
	always_comb begin
		is_load = (func == FUNC_LOAD);
		is_step = (func == FUNC_STEP) && busy_q;
		nx_x    = is_load ? x_start : st_x;
		nx_y    = is_load ? y_start : st_y;
		if (is_load) begin
			nx_done = ld_x_major ? (x_start == x_end) : (y_start == y_end);
		end else begin
			nx_done = x_major_q ? (st_x == goal_x_q) : (st_y == goal_y_q);
		end

		if (is_load || is_step) begin
			pix_x               = nx_x;
			pix_y               = nx_y;
			pix_base            = is_load ? layer_base : base_q;
			pix_flags.valid_res = 1'b1;
			pix_flags.colour    = is_load ? pen : colour_q;
			pix_flags.last      = nx_done;
		end else begin
			pix_x     = '0;
			pix_y     = '0;
			pix_base  = '0;
			pix_flags = '0;
		end
	end

	// State update on each transfer into the next stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q   <= '0;
			cur_y_q   <= '0;
			goal_x_q  <= '0;
			goal_y_q  <= '0;
			tdx_q     <= '0;
			tdy_q     <= '0;
			err_q     <= '0;
			x_neg_q   <= 1'b0;
			y_neg_q   <= 1'b0;
			x_major_q <= 1'b0;
			busy_q    <= 1'b0;
			colour_q  <= 1'b0;
			base_q    <= '0;
		end else if (en) begin
			if (is_load) begin
				cur_x_q   <= x_start;
				cur_y_q   <= y_start;
				goal_x_q  <= x_end;
				goal_y_q  <= y_end;
				tdx_q     <= ld_tdx;
				tdy_q     <= ld_tdy;
				err_q     <= ld_err;
				x_neg_q   <= ld_x_neg;
				y_neg_q   <= ld_y_neg;
				x_major_q <= ld_x_major;
				busy_q    <= !nx_done;
				colour_q  <= pen;
				base_q    <= layer_base;
			end else if (is_step) begin
				cur_x_q <= st_x;
				cur_y_q <= st_y;
				err_q   <= st_err;
				busy_q  <= !nx_done;
			end
		end
	end

endmodule

/* rtl/lps_addr.sv */
// Byte address and bit mask of a pixel in the frame buffer.
module lps_addr #(
	parameter int COORD_BITS = 10
) (
	input  logic [COORD_BITS-1:0] pix_x,
	input  logic [COORD_BITS-1:0] pix_y,
	input  logic [15:0]           pix_base,
	input  lps_pkg::pix_flags_t   pix_flags,
	input  logic [7:0]            bytes_per_line,
	output logic [15:0]           byte_address,
	output logic [7:0]            bit_mask
);
	import lps_pkg::*;

	logic [COORD_BITS+7:0] row_off;
	logic [COORD_BITS-1:0] col_byte;

	// base + y*bytes_per_line + x/8, wrapping at 16 bits
	always_comb begin
		row_off  = (COORD_BITS+8)'(pix_y) * (COORD_BITS+8)'(bytes_per_line);
		col_byte = pix_x >> 3;
		if (pix_flags.valid_res) begin
			byte_address = pix_base + 16'(row_off) + 16'(col_byte);
			bit_mask     = MASK_MSB >> pix_x[2:0];
		end else begin
			byte_address = '0;
			bit_mask     = '0;
		end
	end

endmodule

/* rtl/line_pixel_stepper_unit.sv */
// Top level of the line pixel stepper: input, step and result stages.
//
//  channel | dir | handshake                | carries
//  --------+-----+--------------------------+----------------------------------
//  s_*     | in  | s_tvalid / s_tready      | load or step item, kind in tuser
//  m_*     | out | m_tvalid / m_tready      | one pixel per item, end in tlast
//  cfg_*   | in  | cfg_valid / cfg_ready    | bytes_per_line, always ready
//
// One item per cycle sustained while m_tready stays high; each item is a single
// error-term update in the step stage, so a line of N pixels streams out as
// one load and N-1 steps, through three registers: input, step and result.
// Reset returns to idle with bytes_per_line at 80 and all stages empty.
// A stall on m_tready holds the result; the two stages behind it keep filling,
// and s_tready drops only once all three are occupied.
module line_pixel_stepper_unit #(
	parameter int COORD_BITS = 10
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// s_tdata: layer_base, x_start, y_start, x_end, y_end, pen (low bit up)
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	input  logic [((4*COORD_BITS+17+7)/8)*8-1:0]   s_tdata,
	// s_tuser: func
	input  logic                                   s_tuser,
	// m_tdata: px, py, byte_address, bit_mask, pixel_colour (low bit up)
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	output logic [((2*COORD_BITS+25+7)/8)*8-1:0]   m_tdata,
	// m_tuser: valid_res
	output logic                                   m_tuser,
	output logic                                   m_tlast,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [7:0]                             cfg_data
);
	import lps_pkg::*;

	localparam int CB    = COORD_BITS;
	localparam int OUT_W = 2 * COORD_BITS + 25;
	localparam int OUT_T = ((OUT_W + 7) / 8) * 8;

	// input stage
	logic          v_s1;
	logic          func_s1, pen_s1;
	logic [15:0]   base_s1;
	logic [CB-1:0] xs_s1, ys_s1, xe_s1, ye_s1;

	// step stage
	logic          v_s2;
	logic [CB-1:0] x_s2, y_s2;
	logic [15:0]   base_s2;
	pix_flags_t    flags_s2;

	logic [CB-1:0] step_x, step_y;
	logic [15:0]   step_base;
	pix_flags_t    step_flags;
	logic [15:0]   addr_c;
	logic [7:0]    mask_c;

	logic [7:0]    bpl_q;
	logic          o_free, s2_free, adv1, adv2;

	// Stage flow control
	always_comb begin
		o_free   = !m_tvalid || m_tready;
		adv2     = v_s2 && o_free;
		s2_free  = !v_s2 || o_free;
		adv1     = v_s1 && s2_free;
		s_tready = !v_s1 || s2_free;
	end

	// Configuration register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpl_q <= BPL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			bpl_q <= cfg_data;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			func_s1 <= s_tuser;
			base_s1 <= s_tdata[15:0];
			xs_s1   <= s_tdata[16 + CB - 1 : 16];
			ys_s1   <= s_tdata[16 + 2*CB - 1 : 16 + CB];
			xe_s1   <= s_tdata[16 + 3*CB - 1 : 16 + 2*CB];
			ye_s1   <= s_tdata[16 + 4*CB - 1 : 16 + 3*CB];
			pen_s1  <= s_tdata[16 + 4*CB];
		end
	end

	lps_step #(.COORD_BITS(CB)) u_step (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (adv1),
		.func       (func_s1),
		.layer_base (base_s1),
		.x_start    (xs_s1),
		.y_start    (ys_s1),
		.x_end      (xe_s1),
		.y_end      (ye_s1),
		.pen        (pen_s1),
		.pix_x      (step_x),
		.pix_y      (step_y),
		.pix_base   (step_base),
		.pix_flags  (step_flags)
	);

	// Step register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (s2_free) begin
			v_s2 <= adv1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			x_s2     <= step_x;
			y_s2     <= step_y;
			base_s2  <= step_base;
			flags_s2 <= step_flags;
		end
	end

	lps_addr #(.COORD_BITS(CB)) u_addr (
		.pix_x          (x_s2),
		.pix_y          (y_s2),
		.pix_base       (base_s2),
		.pix_flags      (flags_s2),
		.bytes_per_line (bpl_q),
		.byte_address   (addr_c),
		.bit_mask       (mask_c)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (o_free) begin
			m_tvalid <= adv2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			m_tdata <= OUT_T'({flags_s2.colour, mask_c, addr_c, y_s2, x_s2});
			m_tuser <= flags_s2.valid_res;
			m_tlast <= flags_s2.last;
		end
	end

endmodule

/* rtl/lps_checker.sv */
// Port-level checks for the line pixel stepper, bound to the top level.
module lps_checker #(
	parameter int COORD_BITS = 10
) (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 m_tvalid,
	input logic                                 m_tready,
	input logic [((2*COORD_BITS+25+7)/8)*8-1:0] m_tdata,
	input logic                                 m_tuser,
	input logic                                 m_tlast
);
	localparam int MASK_LO = 2 * COORD_BITS + 16;

	// A stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

	// Step while idle gives an all-zero result
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> (m_tdata == '0) && !m_tlast)
		else $error("idle step result not zero");

	// A pixel has exactly one mask bit
	a_mask_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> $onehot(m_tdata[MASK_LO+7:MASK_LO]))
		else $error("bit mask not one-hot");

	// Mask matches the low column bits
	a_mask_col: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |->
			m_tdata[MASK_LO+7:MASK_LO] == (8'h80 >> m_tdata[2:0]))
		else $error("bit mask does not match column");

endmodule

bind line_pixel_stepper_unit lps_checker #(.COORD_BITS(COORD_BITS)) u_lps_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
